[design/odwm_pkg.sv]
package odwm_pkg;

    // Widths of the stream payloads (fields packed from bit 0, padded to bytes)
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 40;

    localparam int NUM_WHEELS = 4;

    // Magnitude limit of a wheel command
    localparam logic signed [9:0] WHEEL_MAX = 10'sd255;
    localparam logic signed [9:0] WHEEL_MIN = -10'sd255;

    // Operating modes carried on s_axis_tuser
    typedef enum logic {
        OP_SECTOR = 1'b0,
        OP_DIRECT = 1'b1
    } op_t;

    // Wheel index: right front, right rear, left rear, left front
    typedef enum logic [1:0] {
        WHL_RF = 2'd0,
        WHL_RR = 2'd1,
        WHL_LR = 2'd2,
        WHL_LF = 2'd3
    } wheel_idx_t;

    // Term applied to the speed for one wheel in sector mode
    typedef enum logic [2:0] {
        T_ZERO  = 3'd0,
        T_FULL  = 3'd1,
        T_HALF  = 3'd2,
        T_NFULL = 3'd3,
        T_NHALF = 3'd4
    } term_t;

    // One wheel's result: PWM compare value above, direction flag in the low bit
    typedef struct packed {
        logic [7:0] duty;
        logic       reverse;
    } wheel_out_t;

    // Per sector: right front, right rear, left rear, left front
    localparam term_t SECTOR_MIX [16][4] = '{
        '{T_FULL,  T_FULL,  T_NFULL, T_NFULL},
        '{T_FULL,  T_HALF,  T_NFULL, T_NHALF},
        '{T_FULL,  T_ZERO,  T_NFULL, T_ZERO },
        '{T_FULL,  T_NHALF, T_NFULL, T_HALF },
        '{T_FULL,  T_NFULL, T_NFULL, T_FULL },
        '{T_HALF,  T_NFULL, T_NHALF, T_FULL },
        '{T_ZERO,  T_NFULL, T_ZERO,  T_FULL },
        '{T_NHALF, T_NFULL, T_HALF,  T_FULL },
        '{T_NFULL, T_NFULL, T_FULL,  T_FULL },
        '{T_NFULL, T_NHALF, T_FULL,  T_HALF },
        '{T_NFULL, T_ZERO,  T_FULL,  T_ZERO },
        '{T_NFULL, T_HALF,  T_FULL,  T_NHALF},
        '{T_NFULL, T_FULL,  T_FULL,  T_NFULL},
        '{T_NHALF, T_FULL,  T_HALF,  T_NFULL},
        '{T_ZERO,  T_FULL,  T_ZERO,  T_NFULL},
        '{T_HALF,  T_FULL,  T_NHALF, T_NFULL}
    };

endpackage

[design/odwm_wheel.sv]
module odwm_wheel
    import odwm_pkg::*;
(
    input  op_t               operation,
    input  term_t             term,
    input  logic [7:0]        speed,
    input  logic signed [8:0] cmd,
    input  logic signed [8:0] heading_correction,
    output wheel_out_t        result
);

    logic signed [8:0] full;
    logic signed [8:0] half;
    logic signed [8:0] mixed;
    logic signed [9:0] sum;
    logic signed [9:0] clamped;
    logic signed [9:0] shifted;

    // Base command: sector term or direct value
    always_comb begin
        full = $signed({1'b0, speed});
        half = $signed({2'b00, speed[7:1]});
        if (operation == OP_DIRECT) begin
            mixed = cmd;
        end else begin
            case (term)
                T_FULL:  mixed = full;
                T_HALF:  mixed = half;
                T_NFULL: mixed = -full;
                T_NHALF: mixed = -half;
                T_ZERO:  mixed = 9'sd0;
                default: mixed = 9'sd0;
            endcase
        end
    end

    // Correction, clamp to +/-255, sign/duty split
    always_comb begin
        sum = 10'(mixed) + 10'(heading_correction);
        if (sum > WHEEL_MAX) begin
            clamped = WHEEL_MAX;
        end else if (sum < WHEEL_MIN) begin
            clamped = WHEEL_MIN;
        end else begin
            clamped = sum;
        end
        shifted = clamped + WHEEL_MAX;
        result.reverse = clamped[9];
        result.duty    = clamped[9] ? shifted[7:0] : clamped[7:0];
    end

endmodule

[design/omni_drive_wheel_mixer.sv]
// Pipeline: input register, then mix/correct/clamp logic into the result
//   register. Throughput: one transaction per cycle unless output stalls;
//   while a result waits on m_axis_tready, one more input transaction is
//   taken if the input register is empty.
// Reset: synchronous active-low aresetn clears both stage valid flags; no
//   result is presented until a new input transaction arrives.
module omni_drive_wheel_mixer
    import odwm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [3:0] direction, [11:4] speed, [20:12] right_front_cmd,
    // [29:21] right_rear_cmd, [38:30] left_rear_cmd, [47:39] left_front_cmd,
    // [56:48] heading_correction, [63:57] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [0] operation
    input  logic                 s_axis_tuser,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [0] right_front_reverse, [8:1] right_front_duty, [9] right_rear_reverse,
    // [17:10] right_rear_duty, [18] left_rear_reverse, [26:19] left_rear_duty,
    // [27] left_front_reverse, [35:28] left_front_duty, [39:36] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic              s1_valid_reg, s1_valid_next;
    logic              m_valid_reg, m_valid_next;
    logic              s1_ready, s2_ready;

    op_t               op_reg;
    logic [3:0]        dir_reg;
    logic [7:0]        speed_reg;
    logic signed [8:0] cmd_reg [NUM_WHEELS];
    logic signed [8:0] corr_reg;

    wheel_out_t        wheel_res [NUM_WHEELS];
    logic [M_TDATA_W-1:0] tdata_reg, tdata_next;

    // Stage handshakes
    assign s2_ready      = !m_valid_reg || m_axis_tready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign s_axis_tready = s1_ready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = tdata_reg;

    always_comb begin
        s1_valid_next = s1_ready ? s_axis_tvalid : s1_valid_reg;
        m_valid_next  = s2_ready ? s1_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s1_ready) begin
            op_reg          <= op_t'(s_axis_tuser);
            dir_reg         <= s_axis_tdata[3:0];
            speed_reg       <= s_axis_tdata[11:4];
            cmd_reg[WHL_RF] <= $signed(s_axis_tdata[20:12]);
            cmd_reg[WHL_RR] <= $signed(s_axis_tdata[29:21]);
            cmd_reg[WHL_LR] <= $signed(s_axis_tdata[38:30]);
            cmd_reg[WHL_LF] <= $signed(s_axis_tdata[47:39]);
            corr_reg        <= $signed(s_axis_tdata[56:48]);
        end
    end

    // Per-wheel mix, correction and clamp
    for (genvar w = 0; w < NUM_WHEELS; w++) begin : g_wheel
        odwm_wheel u_wheel (
            .operation          (op_reg),
            .term               (SECTOR_MIX[dir_reg][w]),
            .speed              (speed_reg),
            .cmd                (cmd_reg[w]),
            .heading_correction (corr_reg),
            .result             (wheel_res[w])
        );
    end

    assign tdata_next = {4'b0000, wheel_res[WHL_LF], wheel_res[WHL_LR],
                         wheel_res[WHL_RR], wheel_res[WHL_RF]};

    // Result register
    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s2_ready) begin
            tdata_reg <= tdata_next;
        end
    end

endmodule

[design/odwm_checker.sv]
module odwm_props
    import odwm_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic                 s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result stays presented
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result payload changed while stalled");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Result valid after the input and result registers when the output side keeps up
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("result missing two cycles after input transaction");

    // Reverse wheels never reach full duty; padding stays zero
    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[39:36] == 4'b0000
            && !(m_axis_tdata[0] && m_axis_tdata[8:1] == 8'hFF)
            && !(m_axis_tdata[9] && m_axis_tdata[17:10] == 8'hFF)
            && !(m_axis_tdata[18] && m_axis_tdata[26:19] == 8'hFF)
            && !(m_axis_tdata[27] && m_axis_tdata[35:28] == 8'hFF))
        else $error("reverse wheel with full duty or non-zero padding");

endmodule

bind omni_drive_wheel_mixer odwm_props u_odwm_props (.*);
